@@ src/isrt_pkg.sv @@
// Shared constants and types for the insertion sorter cell chain.
`timescale 1ns / 1ps
`default_nettype none

package isrt_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int DATA_W    = 32;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic signed [DATA_W-1:0] val;  // held element
    logic                     occ;  // cell holds an element
    logic                     sfx;  // this cell and all held cells to its right move up
  } cell_link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                     insert;  // insert new_val this cycle
    logic                     shift;   // move the list one cell toward the output
    logic                     desc;    // descending order
    logic signed [DATA_W-1:0] new_val; // incoming element
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/isrt_cell.sv @@
// One cell of the sorting chain: holds one element and its occupied flag.
`timescale 1ns / 1ps
`default_nettype none

module isrt_cell
  import isrt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire cell_link_t left_in,
  input  wire cell_link_t right_in,
  output cell_link_t      link
);

  logic signed [DATA_W-1:0] val;
  logic                     occ;
  logic                     goes_after;

  // held element must move past the incoming one
  always_comb begin
    goes_after = occ && (ctrl.desc ? (val < ctrl.new_val) : (val > ctrl.new_val));
  end

  assign link.val = val;
  assign link.occ = occ;
  // empty cells pass the chain through
  assign link.sfx = !occ || (goes_after && right_in.sfx);

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (link.sfx) begin
        val <= left_in.sfx ? left_in.val : ctrl.new_val;
      end
    end else if (ctrl.shift) begin
      val <= right_in.val;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.insert) begin
      occ <= occ | left_in.occ;
    end else if (ctrl.shift) begin
      occ <= right_in.occ;
    end
  end

endmodule

`default_nettype wire

@@ src/insertion_sorter_core.sv @@
// Top level of the insertion sorter: cell chain, input/output handshakes and config bit.
`timescale 1ns / 1ps
`default_nettype none

// Stable insertion sorter for signed 32-bit values. Values arrive on the s_ side
// and are inserted into a chain of MAX_ITEMS cells, so the input side
// takes one value per clock while a set is being collected. Each cell compares its
// element with the incoming value; a chain of flags running from the tail tells
// every cell whether it moves up one place, and the cell where that run starts
// takes the new value. Equal values go after those already held. When a value with
// s_tlast arrives it is inserted and the chain then drains from cell 0 to the m_
// side, one result per cycle while m_tready is high, the final one marked with
// m_tlast. During draining s_tready is low, so no value of the next set is taken
// until this set has drained. Values arriving with the chain full are dropped and
// every result of that set carries m_tuser (dropped) high. The descending bit is
// written on the cfg_ channel (always ready) and must only change while idle.
module insertion_sorter_core
  import isrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic        s_tlast,   // last_in
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] sorted_value
  output logic             m_tlast,   // last_out
  output logic             m_tuser,   // [0] dropped
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data   // descending
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic       state;
  logic       descending;
  logic       overflow_seen;
  logic       in_xfer;
  logic       out_xfer;
  logic       full;
  cell_ctrl_t ctrl;
  cell_link_t links [MAX_ITEMS];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign full      = links[MAX_ITEMS-1].occ;

  // output comes straight from the head cell register
  assign m_tvalid  = (state == ST_EMIT);
  assign m_tdata   = links[0].val;
  assign m_tlast   = !links[1].occ;
  assign m_tuser   = overflow_seen;
  assign out_xfer  = m_tvalid && m_tready;

  assign ctrl.insert  = in_xfer && !full;
  assign ctrl.shift   = out_xfer;
  assign ctrl.desc    = descending;
  assign ctrl.new_val = s_tdata;

  generate
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      cell_link_t left_in;
      cell_link_t right_in;

      if (i == 0) begin : g_head
        // head: always takes the new value when the run of moves reaches it
        assign left_in.val = s_tdata;
        assign left_in.occ = 1'b1;
        assign left_in.sfx = 1'b0;
      end else begin : g_mid
        assign left_in = links[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
        assign right_in.val = links[i].val;
        assign right_in.occ = 1'b0;
        assign right_in.sfx = 1'b1;
      end else begin : g_body
        assign right_in = links[i+1];
      end

      isrt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .left_in  (left_in),
        .right_in (right_in),
        .link     (links[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      descending <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      overflow_seen <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (full) begin
              overflow_seen <= 1'b1;
            end
            // a set always holds at least one element here
            if (s_tlast) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_xfer && m_tlast) begin
            state         <= ST_IDLE;
            overflow_seen <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_insertion_sorter_core.sv @@
// Self-checking testbench for the insertion sorter core.
`timescale 1ns / 1ps

module tb_insertion_sorter_core;
  import isrt_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int RESET_CYCLES  = 4;
  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    bit                       last;
    bit                       dropped;
  } sorted_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  insertion_sorter_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Sorter shadow state
  logic signed [DATA_W-1:0] held_list [MAX_ITEMS];
  int                       held_n = 0;
  bit                       lost_in_set = 1'b0;
  bit                       desc_order = 1'b0;
  sorted_item_t             pending_sorted [$];

  bit quiet_phase = 1'b0;
  int n_fails = 0;
  int n_items_sent = 0;
  int n_sets = 0;
  int n_results = 0;
  int n_overflow_sets = 0;
  int n_order_writes = 0;
  int n_mid_flips = 0;

  // Insert one accepted value; on the closing value queue the whole list.
  task automatic sort_insert(input logic signed [DATA_W-1:0] v, input bit fin);
    int pos;
    sorted_item_t item;
    if (held_n < MAX_ITEMS) begin
      pos = held_n;
      // equal values stay ahead of the new one
      while (pos > 0 && (desc_order ? (held_list[pos-1] < v) : (held_list[pos-1] > v))) begin
        held_list[pos] = held_list[pos-1];
        pos--;
      end
      held_list[pos] = v;
      held_n++;
    end else begin
      lost_in_set = 1'b1;
    end
    if (fin) begin
      for (int k = 0; k < held_n; k++) begin
        item.value   = held_list[k];
        item.last    = (k == held_n - 1);
        item.dropped = lost_in_set;
        pending_sorted.push_back(item);
      end
      if (lost_in_set) n_overflow_sets++;
      n_sets++;
      held_n = 0;
      lost_in_set = 1'b0;
    end
  endtask

  // Entered and left at a falling edge; valid stays high unless a random gap follows.
  task automatic send_item(input logic signed [DATA_W-1:0] v, input bit fin);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sort_insert(v, fin);
    n_items_sent++;
    @(negedge clk);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic stop_input();
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_sorted.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Input must be stopped and drained before this is called.
  task automatic write_order(input bit desc);
    cfg_valid <= 1'b1;
    cfg_data  <= desc;
    do @(posedge clk); while (!cfg_ready);
    desc_order = desc;
    n_order_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $signed($urandom_range(0, 15)) - 8;  // many duplicates
      1:       return $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_set(input int size, input bit flip_mid);
    for (int i = 0; i < size; i++) begin
      if (flip_mid && i == size / 2) begin
        stop_input();
        wait_drained();
        write_order(!desc_order);
        n_mid_flips++;
      end
      send_item(pick_value(), i == size - 1);
    end
  endtask

  task automatic run_random_sets(input int target);
    int start;
    int size;
    int pick;
    start = n_items_sent;
    while (n_items_sent - start < target) begin
      if ($urandom_range(0, 3) == 0) begin
        stop_input();
        wait_drained();
        write_order(1'($urandom_range(0, 1)));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      else if (pick == 1) size = MAX_ITEMS;
      else                size = $urandom_range(1, 10);
      send_random_set(size, size > 1 && $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic test_ascending_extremes();
    send_item(MOST_NEG, 1'b0);
    send_item(MOST_POS, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b1);
  endtask

  task automatic test_descending_duplicates();
    stop_input();
    wait_drained();
    write_order(1'b1);
    send_item(-1, 1'b0);
    send_item(MOST_NEG, 1'b0);
    send_item(-1, 1'b1);
  endtask

  // Order flips while a set is partly held; the held part is not re-sorted.
  task automatic test_mixed_order();
    stop_input();
    wait_drained();
    write_order(1'b0);
    send_item(10, 1'b0);
    stop_input();
    wait_drained();
    write_order(1'b1);
    n_mid_flips++;
    send_item(-3, 1'b0);
    send_item(7, 1'b1);
  endtask

  // Fill the list, then close the set with a value that no longer fits.
  task automatic test_full_list();
    stop_input();
    wait_drained();
    for (int i = 0; i < MAX_ITEMS; i++) send_item(pick_value(), 1'b0);
    send_item(MOST_POS, 1'b1);
  endtask

  task automatic test_random_traffic();
    run_random_sets(85);
  endtask

  task automatic test_full_throughput();
    quiet_phase = 1'b1;
    run_random_sets(30);
  endtask

  // Output side backpressure
  initial begin
    int left;
    bit stalling;
    left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_phase) begin
        m_tready <= 1'b1;
      end else begin
        if (left == 0) begin
          stalling = ($urandom_range(0, 3) == 0);
          left = stalling ? $urandom_range(1, 10) : $urandom_range(1, 20);
        end
        left--;
        m_tready <= !stalling;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    sorted_item_t exp_item;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sorted.size() == 0) begin
        $error("unexpected result: sorted_value %0d", $signed(m_tdata));
        n_fails++;
      end else begin
        exp_item = pending_sorted.pop_front();
        n_results++;
        if (m_tdata !== exp_item.value) begin
          $error("sorted_value: expected %0d, got %0d", exp_item.value, $signed(m_tdata));
          n_fails++;
        end
        if (m_tlast !== exp_item.last) begin
          $error("last_out: expected %0d, got %0d", exp_item.last, m_tlast);
          n_fails++;
        end
        if (m_tuser !== exp_item.dropped) begin
          $error("dropped: expected %0d, got %0d", exp_item.dropped, m_tuser);
          n_fails++;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_ascending_extremes();
    test_descending_duplicates();
    test_mixed_order();
    test_full_list();
    test_random_traffic();
    test_full_throughput();
    stop_input();
    for (int i = 0; i < 20000 && pending_sorted.size() != 0; i++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_sorted.size() != 0) begin
      $error("%0d sorted results never arrived", pending_sorted.size());
      n_fails++;
    end
    $display("coverage: %0d values in %0d sets, %0d results checked, %0d sets overflowed",
             n_items_sent, n_sets, n_results, n_overflow_sets);
    $display("coverage: %0d order writes, %0d of them inside a set", n_order_writes,
             n_mid_flips);
    if (n_fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/isrt_pkg.sv
src/isrt_cell.sv
src/insertion_sorter_core.sv
dv/tb_insertion_sorter_core.sv
